// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cda_pkg.sv -----
`timescale 1ns / 1ps

package cda_pkg;

  // field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned DIFF_W     = 23;
  localparam int unsigned ACC_W      = 23;
  localparam int unsigned DOY_W      = 9;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned LEAP_Y_W   = 18;

  // defaults and limits
  localparam int unsigned MAX_YEAR_DEF  = 9999;
  localparam int unsigned YEAR_FIELD_MAX = 16383;
  localparam logic [23:0] MAX_OFFSET    = 24'd65535;

  // selector codes
  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIFF = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // calendar constants
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;
  localparam int unsigned        YEARS_PER_ERA = 400;
  localparam logic [ACC_W-1:0]   DAYS_PER_ERA  = 23'd146097;

  // divisibility by 25 through the modular inverse mod 2^16
  localparam logic [15:0] INV25     = 16'h5C29;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  // difference saturation limits
  localparam logic signed [DIFF_W+1:0] DIFF_HI = 25'sd4194303;
  localparam logic signed [DIFF_W+1:0] DIFF_LO = -25'sd4194304;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clamp;
    logic prep;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fin;
  } sts_t;

  // gregorian leap rule: by 4, not by 100 unless by 400
  function automatic logic leap_year(input logic [LEAP_Y_W-1:0] y);
    logic [15:0] q;
    logic [15:0] prod;
    logic        by25;
    q    = y[LEAP_Y_W-1:2];
    prod = q * INV25;
    by25 = (prod <= DIV25_LIM);
    return (y[1:0] == 2'b00) && (!by25 || (y[3:2] == 2'b00));
  endfunction

  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    priority if (m == '0) begin
      r = MONTH_JAN;
    end else if (m > MONTH_DEC) begin
      r = MONTH_DEC;
    end else begin
      r = m;
    end
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd2: begin
        r = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        r = 5'd30;
      end
      default: begin
        r = DAY_LAST;
      end
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0] d,
                                                 input logic [DAY_W-1:0] len);
    logic [DAY_W-1:0] r;
    priority if (d == '0) begin
      r = 5'd1;
    end else if (d > len) begin
      r = len;
    end else begin
      r = d;
    end
    return r;
  endfunction

  // days in the year before the first of month m, common year
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/cda_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cda_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output cda_pkg::cmd_t cmd,
  input  cda_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLAMP  = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_STEP   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // sequencing of one request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (sts.fin) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register occupancy
  always_comb begin
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEXT(a_accept_starts_work, clk, rst_n, in_tvalid && in_tready, state_r == ST_CLAMP, "accepted request did not start")
  `ASSERT_NEXT(a_result_not_overwritten, clk, rst_n, state_r == ST_FINISH && out_tvalid && !out_tready, state_r == ST_FINISH, "finished result written over a waiting one")

endmodule

// ----- src/cda_datapath.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cda_datapath #(
  parameter int unsigned MAX_YEAR = cda_pkg::MAX_YEAR_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [cda_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [cda_pkg::KIND_W-1:0]       in_kind,
  input  cda_pkg::cmd_t                    cmd,
  output cda_pkg::sts_t                    sts,
  output logic [cda_pkg::OUT_DATA_W-1:0]   out_data
);

  localparam int unsigned YEAR_TOP = (MAX_YEAR > cda_pkg::YEAR_FIELD_MAX) ?
                                     MAX_YEAR : cda_pkg::YEAR_FIELD_MAX;
  localparam int unsigned YW   = $clog2(YEAR_TOP + 2);
  localparam int unsigned YPAD = cda_pkg::LEAP_Y_W - YW;
  localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);
  localparam logic [YW-1:0] ERA_Y = YW'(cda_pkg::YEARS_PER_ERA);
  localparam int unsigned OUT_PAD = cda_pkg::OUT_DATA_W - cda_pkg::YEAR_W - cda_pkg::MONTH_W
                                    - cda_pkg::DAY_W - cda_pkg::DIFF_W - 4;

  // request fields
  logic [cda_pkg::YEAR_W-1:0]  f_y1, f_y2;
  logic [cda_pkg::MONTH_W-1:0] f_m1, f_m2;
  logic [cda_pkg::DAY_W-1:0]   f_d1, f_d2;
  logic [cda_pkg::OFF_W-1:0]   f_off;

  assign f_y1  = in_data[13:0];
  assign f_m1  = in_data[17:14];
  assign f_d1  = in_data[22:18];
  assign f_off = in_data[38:23];
  assign f_y2  = in_data[52:39];
  assign f_m2  = in_data[56:53];
  assign f_d2  = in_data[61:57];

  // working state
  logic [cda_pkg::KIND_W-1:0]    kind_r, kind_nxt;
  logic [YW-1:0]                 wy_r, wy_nxt, yb_r, yb_nxt;
  logic [cda_pkg::MONTH_W-1:0]   wm_r, wm_nxt, mb_r, mb_nxt;
  logic [cda_pkg::DAY_W-1:0]     wd_r, wd_nxt, db_r, db_nxt;
  logic [cda_pkg::OFF_W-1:0]     off_r, off_nxt;
  logic [cda_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [cda_pkg::DOY_W:0] base_r, base_nxt;
  logic                          neg_r, neg_nxt;
  logic                          less_r, less_nxt, equal_r, equal_nxt;
  logic                          valid_r, valid_nxt, door_r, door_nxt;
  logic                          fin_r, fin_nxt;
  logic [cda_pkg::OUT_DATA_W-1:0] out_r, out_nxt;

  // calendar lookups on the current registers
  logic                        leap_a, leap_b;
  logic [cda_pkg::MONTH_W-1:0] mc_a, mc_b;
  logic [cda_pkg::DAY_W-1:0]   len_a, len_b, dc_a, dc_b, dcur;
  logic [cda_pkg::DOY_W-1:0]   doy_a, doy_b;
  logic [5:0]                  rem_a;
  logic [YW-1:0]               gap;
  logic                        valid_raw;

  assign leap_a = cda_pkg::leap_year({{YPAD{1'b0}}, wy_r});
  assign leap_b = cda_pkg::leap_year({{YPAD{1'b0}}, yb_r});
  assign mc_a   = cda_pkg::clamp_month(wm_r);
  assign mc_b   = cda_pkg::clamp_month(mb_r);
  assign len_a  = cda_pkg::month_len(leap_a, mc_a);
  assign len_b  = cda_pkg::month_len(leap_b, mc_b);
  assign dc_a   = cda_pkg::clamp_day(wd_r, len_a);
  assign dc_b   = cda_pkg::clamp_day(db_r, len_b);
  assign doy_a  = cda_pkg::cum_days(wm_r) + cda_pkg::DOY_W'(wd_r) - 9'd1
                  + cda_pkg::DOY_W'(leap_a && (wm_r > cda_pkg::MONTH_FEB));
  assign doy_b  = cda_pkg::cum_days(mb_r) + cda_pkg::DOY_W'(db_r) - 9'd1
                  + cda_pkg::DOY_W'(leap_b && (mb_r > cda_pkg::MONTH_FEB));
  assign rem_a  = 6'(len_a) - 6'(wd_r) + 6'd1;
  assign dcur   = (wd_r == '0) ? len_a : wd_r;
  assign gap    = yb_r - wy_r;
  assign valid_raw = (wm_r != '0) && (wm_r <= cda_pkg::MONTH_DEC) && (wd_r != '0)
                     && (wd_r <= len_a);

  // difference assembly
  logic signed [cda_pkg::DIFF_W+1:0] acc_s, yrs_s, tot_s;
  logic [cda_pkg::DIFF_W-1:0]        diff_sat;

  assign acc_s = $signed({2'b00, acc_r});
  assign yrs_s = neg_r ? -acc_s : acc_s;
  assign tot_s = yrs_s + {{(cda_pkg::DIFF_W + 1 - cda_pkg::DOY_W){base_r[cda_pkg::DOY_W]}},
                          base_r};

  always_comb begin
    priority if (tot_s > cda_pkg::DIFF_HI) begin
      diff_sat = cda_pkg::DIFF_HI[cda_pkg::DIFF_W-1:0];
    end else if (tot_s < cda_pkg::DIFF_LO) begin
      diff_sat = cda_pkg::DIFF_LO[cda_pkg::DIFF_W-1:0];
    end else begin
      diff_sat = tot_s[cda_pkg::DIFF_W-1:0];
    end
  end

  // next-state logic per command
  always_comb begin
    logic [cda_pkg::YEAR_W-1:0]  ry;
    logic [cda_pkg::MONTH_W-1:0] rm;
    logic [cda_pkg::DAY_W-1:0]   rd;
    logic [cda_pkg::DIFF_W-1:0]  rdiff;
    logic                        roor;

    kind_nxt  = kind_r;
    wy_nxt    = wy_r;
    wm_nxt    = wm_r;
    wd_nxt    = wd_r;
    yb_nxt    = yb_r;
    mb_nxt    = mb_r;
    db_nxt    = db_r;
    off_nxt   = off_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    neg_nxt   = neg_r;
    less_nxt  = less_r;
    equal_nxt = equal_r;
    valid_nxt = valid_r;
    door_nxt  = door_r;
    fin_nxt   = fin_r;
    out_nxt   = out_r;
    ry        = '0;
    rm        = '0;
    rd        = '0;
    rdiff     = '0;
    roor      = 1'b0;

    // capture request, compare raw fields
    if (cmd.load) begin
      kind_nxt  = in_kind;
      wy_nxt    = YW'(f_y1);
      wm_nxt    = f_m1;
      wd_nxt    = f_d1;
      yb_nxt    = YW'(f_y2);
      mb_nxt    = f_m2;
      db_nxt    = f_d2;
      off_nxt   = ({8'd0, f_off} > cda_pkg::MAX_OFFSET) ?
                  cda_pkg::MAX_OFFSET[cda_pkg::OFF_W-1:0] : f_off;
      less_nxt  = {f_y1, f_m1, f_d1} < {f_y2, f_m2, f_d2};
      equal_nxt = {f_y1, f_m1, f_d1} == {f_y2, f_m2, f_d2};
      door_nxt  = (f_y1 == '0) || (YW'(f_y1) > MAX_Y) || (f_y2 == '0) || (YW'(f_y2) > MAX_Y);
      fin_nxt   = 1'b0;
    end

    // legalize both dates
    if (cmd.clamp) begin
      wm_nxt    = mc_a;
      wd_nxt    = dc_a;
      mb_nxt    = mc_b;
      db_nxt    = dc_b;
      valid_nxt = valid_raw;
    end

    // day-of-year offset and year order for the difference
    if (cmd.prep) begin
      base_nxt = $signed({1'b0, doy_a}) - $signed({1'b0, doy_b});
      acc_nxt  = '0;
      neg_nxt  = (wy_r < yb_r);
      fin_nxt  = (kind_r == cda_pkg::KIND_NONE);
      if (kind_r == cda_pkg::KIND_DIFF) begin
        wy_nxt = (wy_r < yb_r) ? wy_r : yb_r;
        yb_nxt = (wy_r < yb_r) ? yb_r : wy_r;
      end
    end

    // one month, one year or one 400-year era per step
    if (cmd.step) begin
      unique case (kind_r)
        cda_pkg::KIND_ADD: begin
          priority if (wy_r > MAX_Y) begin
            fin_nxt = 1'b1;
          end else if ({10'd0, rem_a} > off_r) begin
            wd_nxt  = wd_r + off_r[cda_pkg::DAY_W-1:0];
            fin_nxt = 1'b1;
          end else begin
            off_nxt = off_r - cda_pkg::OFF_W'(rem_a);
            wd_nxt  = 5'd1;
            if (wm_r == cda_pkg::MONTH_DEC) begin
              wm_nxt = cda_pkg::MONTH_JAN;
              wy_nxt = wy_r + YW'(1);
            end else begin
              wm_nxt = wm_r + 4'd1;
            end
          end
        end
        cda_pkg::KIND_SUB: begin
          priority if (wy_r == '0) begin
            fin_nxt = 1'b1;
          end else if (cda_pkg::OFF_W'(dcur) > off_r) begin
            wd_nxt  = dcur - off_r[cda_pkg::DAY_W-1:0];
            fin_nxt = 1'b1;
          end else begin
            // zero day marks the last day of the month entered
            off_nxt = off_r - cda_pkg::OFF_W'(dcur);
            wd_nxt  = '0;
            if (wm_r == cda_pkg::MONTH_JAN) begin
              wm_nxt = cda_pkg::MONTH_DEC;
              wy_nxt = wy_r - YW'(1);
            end else begin
              wm_nxt = wm_r - 4'd1;
            end
          end
        end
        cda_pkg::KIND_DIFF: begin
          priority if (gap >= ERA_Y) begin
            acc_nxt = acc_r + cda_pkg::DAYS_PER_ERA;
            wy_nxt  = wy_r + ERA_Y;
          end else if (gap != '0) begin
            acc_nxt = acc_r + cda_pkg::ACC_W'(9'd365 + 9'(leap_a));
            wy_nxt  = wy_r + YW'(1);
          end else begin
            fin_nxt = 1'b1;
          end
        end
        default: begin
          fin_nxt = 1'b1;
        end
      endcase
    end

    // result assembly with saturation
    if (cmd.finish) begin
      unique case (kind_r)
        cda_pkg::KIND_ADD, cda_pkg::KIND_SUB: begin
          priority if (wy_r == '0) begin
            roor = 1'b1;
            ry   = 14'd1;
            rm   = cda_pkg::MONTH_JAN;
            rd   = 5'd1;
          end else if (wy_r > MAX_Y) begin
            roor = 1'b1;
            ry   = MAX_Y[cda_pkg::YEAR_W-1:0];
            rm   = cda_pkg::MONTH_DEC;
            rd   = cda_pkg::DAY_LAST;
          end else begin
            ry = wy_r[cda_pkg::YEAR_W-1:0];
            rm = wm_r;
            rd = wd_r;
          end
        end
        cda_pkg::KIND_DIFF: begin
          rdiff = diff_sat;
          roor  = door_r;
        end
        default: begin
          roor = 1'b0;
        end
      endcase
      out_nxt = {{OUT_PAD{1'b0}}, roor, valid_r, equal_r, less_r, rdiff, rd, rm, ry};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= 1'b0;
    end else begin
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    wy_r    <= wy_nxt;
    wm_r    <= wm_nxt;
    wd_r    <= wd_nxt;
    yb_r    <= yb_nxt;
    mb_r    <= mb_nxt;
    db_r    <= db_nxt;
    off_r   <= off_nxt;
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    neg_r   <= neg_nxt;
    less_r  <= less_nxt;
    equal_r <= equal_nxt;
    valid_r <= valid_nxt;
    door_r  <= door_nxt;
    out_r   <= out_nxt;
  end

  assign sts.fin  = fin_r;
  assign out_data = out_r;

  // step qualifiers for the checks below
  logic step_sub, step_diff;

  assign step_sub  = cmd.step && (kind_r == cda_pkg::KIND_SUB);
  assign step_diff = cmd.step && (kind_r == cda_pkg::KIND_DIFF);

  `ASSERT_IMPLIES(a_no_step_after_fin, clk, rst_n, fin_r, !cmd.step, "step after finish")
  `ASSERT_NEXT(a_sub_year_never_rises, clk, rst_n, step_sub, wy_r <= $past(wy_r), "year rose")
  `ASSERT_NEXT(a_diff_walk_bounded, clk, rst_n, step_diff, wy_r <= yb_r, "walk overshot")

endmodule

// ----- src/calendar_date_arithmetic.sv -----
`timescale 1ns / 1ps

// Gregorian date add, subtract and difference. A request on in_* carries a
// selector in in_tuser (add offset, subtract offset, first minus second) and
// two dates plus a day offset in in_tdata; each request gives one result on
// out_*. Dates are legalized first (month and day clamped), then a single
// stepping loop in the datapath walks the calendar: add and subtract move one
// month per cycle; the difference walks 400-year eras and then single years.
// One request is worked at a time; a finished result sits in an output
// register, so the next request is taken while it waits. Shifted dates
// outside 1..MAX_YEAR saturate and set out_of_range.
module calendar_date_arithmetic #(
  parameter int unsigned MAX_YEAR = cda_pkg::MAX_YEAR_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // first_year, first_month, first_day, offset_days, second_year,
  // second_month, second_day
  input  logic [cda_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [cda_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // result_year, result_month, result_day, day_difference, first_less,
  // dates_equal, date_valid, out_of_range
  output logic [cda_pkg::OUT_DATA_W-1:0] out_tdata
);

  cda_pkg::cmd_t cmd;
  cda_pkg::sts_t sts;

  // sequencer
  cda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // calendar datapath and result register
  cda_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_tdata),
    .in_kind  (in_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule
